// ----- rtl/hta_pkg.sv -----
// Shared constants and codes for the triangle area block.
package hta_pkg;

  localparam int SIDE_BITS_DEF = 16;
  localparam int SIDE_IN_W     = 16;
  localparam int COORD_W       = 15;
  localparam int AREA_W        = 36;
  localparam int DIST_W        = 32;

  localparam logic OP_SIDES   = 1'b0;
  localparam logic OP_POINTS  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

// ----- rtl/hta_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage, several lanes.
module hta_isqrt #(
  parameter int IN_W  = 32,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [LANES-1:0][IN_W-1:0]        radicand_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output logic                              valid_o,
  output logic [LANES-1:0][(IN_W+1)/2-1:0]  root_o,
  output logic [TAG_W-1:0]                  tag_o
);

  localparam int RT_W = (IN_W + 1) / 2;
  localparam int TW   = 2 * RT_W + 2;

  logic                  vld_q  [RT_W];
  logic [TAG_W-1:0]      tag_q  [RT_W];
  logic [IN_W-1:0]       rem_q  [RT_W][LANES];
  logic [RT_W-1:0]       root_q [RT_W][LANES];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int BIT = RT_W - 1 - k;

    logic             src_vld;
    logic [TAG_W-1:0] src_tag;

    if (k == 0) begin : g_first
      assign src_vld = valid_i;
      assign src_tag = tag_i;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src_tag = tag_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k] <= src_tag;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [IN_W-1:0] src_rem;
      logic [RT_W-1:0] src_root;
      logic [TW-1:0]   trial;
      logic [TW-1:0]   rem_ext;
      logic            take;
      logic [IN_W-1:0] rem_d;
      logic [RT_W-1:0] root_d;

      if (k == 0) begin : g_first
        assign src_rem  = radicand_i[l];
        assign src_root = '0;
      end else begin : g_next
        assign src_rem  = rem_q[k-1][l];
        assign src_root = root_q[k-1][l];
      end

      always_comb begin
        rem_ext = TW'(src_rem);
        trial   = (TW'(src_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        take    = rem_ext >= trial;
        rem_d   = take ? IN_W'(rem_ext - trial) : src_rem;
        root_d  = take ? (src_root | (RT_W'(1) << BIT)) : src_root;
      end

      always_ff @(posedge clk_i) begin
        rem_q[k][l]  <= rem_d;
        root_q[k][l] <= root_d;
      end
    end
  end

  assign valid_o = vld_q[RT_W-1];
  assign tag_o   = tag_q[RT_W-1];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root_o[l] = root_q[RT_W-1][l];
  end

endmodule

// ----- rtl/heron_triangle_area_core.sv -----
// Top level of the pipelined triangle area engine (four times the Heron area).
//
// A query is taken at each rising edge where start_i is high and busy_o is low.
// busy_o is always low: the pipeline takes a new item in every cycle.
// operation_i selects side lengths (side_*_i) or corner points (point_*_i);
// in point mode each side is the floored root of the squared corner distance, saturated to SIDE_BITS bits.
// Exactly one result leaves per item, in order, on status_o and
// area_times_four_o, marked by valid_o for one cycle.
// status_o is high with a zero area when the strict triangle inequality fails.
// The pipeline runs from the input register through the difference, square and
// sum stages, the 16-stage distance root, the multiply stages and the
// bit-per-stage root of the Heron product, which has 2*SIDE_BITS + 3 stages.
// Throughput is one item per cycle.
// Reset clears all valid bits, so no result appears until items are taken.
// The receiver cannot stall; each result must be taken in its strobe cycle.
module heron_triangle_area_core #(
  parameter int SIDE_BITS = hta_pkg::SIDE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               operation_i,
  input  logic [hta_pkg::SIDE_IN_W-1:0]      side_a_i,
  input  logic [hta_pkg::SIDE_IN_W-1:0]      side_b_i,
  input  logic [hta_pkg::SIDE_IN_W-1:0]      side_c_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_a_x_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_a_y_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_b_x_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_b_y_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_c_x_i,
  input  logic signed [hta_pkg::COORD_W-1:0] point_c_y_i,
  output logic                               valid_o,
  output logic                               status_o,
  output logic [hta_pkg::AREA_W-1:0]         area_times_four_o
);

  localparam int SB    = SIDE_BITS;
  localparam int SIN   = hta_pkg::SIDE_IN_W;
  localparam int CW    = hta_pkg::COORD_W;
  localparam int DW    = CW + 1;
  localparam int QW    = hta_pkg::DIST_W;
  localparam int DRT_W = (QW + 1) / 2;
  localparam int MW    = (SB > DRT_W) ? SB : DRT_W;
  localparam int FW    = SB + 2;
  localparam int P12_W = 2 * SB + 3;
  localparam int P34_W = 2 * SB + 2;
  localparam int L12_W = SB + 2;
  localparam int H12_W = P12_W - L12_W;
  localparam int L34_W = SB + 1;
  localparam int H34_W = P34_W - L34_W;
  localparam int PW    = 4 * SB + 5;
  localparam int RT_W  = (PW + 1) / 2;
  localparam int AW    = hta_pkg::AREA_W;
  localparam int TAG_W = 1 + 3 * SB;
  localparam logic [SB-1:0] SMAX = '1;

  assign busy_o = 1'b0;

  // Input register.
  logic                 v0_q;
  logic                 op0_q;
  logic [SB-1:0]        sa0_q, sb0_q, sc0_q;
  logic signed [CW-1:0] ax0_q, ay0_q, bx0_q, by0_q, cx0_q, cy0_q;
  logic [SIN+SB-1:0]    sa_ext, sb_ext, sc_ext;

  assign sa_ext = (SIN + SB)'(side_a_i);
  assign sb_ext = (SIN + SB)'(side_b_i);
  assign sc_ext = (SIN + SB)'(side_c_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    op0_q <= operation_i;
    sa0_q <= sa_ext[SB-1:0];
    sb0_q <= sb_ext[SB-1:0];
    sc0_q <= sc_ext[SB-1:0];
    ax0_q <= point_a_x_i;
    ay0_q <= point_a_y_i;
    bx0_q <= point_b_x_i;
    by0_q <= point_b_y_i;
    cx0_q <= point_c_x_i;
    cy0_q <= point_c_y_i;
  end

  // Coordinate differences.
  logic                 v1_q;
  logic [TAG_W-1:0]     tag1_q;
  logic signed [DW-1:0] d1_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q  <= {op0_q, sa0_q, sb0_q, sc0_q};
    d1_q[0] <= {bx0_q[CW-1], bx0_q} - {ax0_q[CW-1], ax0_q};
    d1_q[1] <= {by0_q[CW-1], by0_q} - {ay0_q[CW-1], ay0_q};
    d1_q[2] <= {cx0_q[CW-1], cx0_q} - {bx0_q[CW-1], bx0_q};
    d1_q[3] <= {cy0_q[CW-1], cy0_q} - {by0_q[CW-1], by0_q};
    d1_q[4] <= {cx0_q[CW-1], cx0_q} - {ax0_q[CW-1], ax0_q};
    d1_q[5] <= {cy0_q[CW-1], cy0_q} - {ay0_q[CW-1], ay0_q};
  end

  // Squares.
  logic             v2_q;
  logic [TAG_W-1:0] tag2_q;
  logic [QW-1:0]    sq2_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_sq
    logic signed [2*DW-1:0] sq;
    assign sq = d1_q[i] * d1_q[i];
    always_ff @(posedge clk_i) begin
      sq2_q[i] <= QW'(unsigned'(sq));
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag1_q;
  end

  // Squared distances.
  logic                     v3_q;
  logic [TAG_W-1:0]         tag3_q;
  logic [2:0][QW-1:0]       dist3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag3_q     <= tag2_q;
    dist3_q[0] <= sq2_q[0] + sq2_q[1];
    dist3_q[1] <= sq2_q[2] + sq2_q[3];
    dist3_q[2] <= sq2_q[4] + sq2_q[5];
  end

  // Distance roots.
  logic                    vr_w;
  logic [TAG_W-1:0]        tagr_w;
  logic [2:0][DRT_W-1:0]   rootd_w;

  hta_isqrt #(
    .IN_W  (QW),
    .LANES (3),
    .TAG_W (TAG_W)
  ) u_dist_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3_q),
    .radicand_i (dist3_q),
    .tag_i      (tag3_q),
    .valid_o    (vr_w),
    .root_o     (rootd_w),
    .tag_o      (tagr_w)
  );

  // Side selection with saturation.
  logic          op_r;
  logic [SB-1:0] tsa, tsb, tsc;
  logic [SB-1:0] sat_side [3];

  assign {op_r, tsa, tsb, tsc} = tagr_w;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [MW-1:0] r_ext;
    assign r_ext       = MW'(rootd_w[i]);
    assign sat_side[i] = (r_ext > MW'(SMAX)) ? SMAX : r_ext[SB-1:0];
  end

  logic          v4_q;
  logic [SB-1:0] a4_q, b4_q, c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vr_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_r == hta_pkg::OP_POINTS) begin
      a4_q <= sat_side[0];
      b4_q <= sat_side[1];
      c4_q <= sat_side[2];
    end else begin
      a4_q <= tsa;
      b4_q <= tsb;
      c4_q <= tsc;
    end
  end

  // Heron factors and the triangle check.
  logic          v5_q;
  logic          ok5_q;
  logic [FW-1:0] f1_5_q, f2_5_q, f3_5_q, f4_5_q;
  logic [FW-1:0] ea, eb, ec, s_bc, s_ac, s_ab;

  assign ea   = FW'(a4_q);
  assign eb   = FW'(b4_q);
  assign ec   = FW'(c4_q);
  assign s_bc = eb + ec;
  assign s_ac = ea + ec;
  assign s_ab = ea + eb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok5_q  <= (ea < s_bc) && (eb < s_ac) && (ec < s_ab);
    f1_5_q <= s_ab + ec;
    f2_5_q <= s_bc - ea;
    f3_5_q <= s_ac - eb;
    f4_5_q <= s_ab - ec;
  end

  // Pair products.
  logic             v6_q, ok6_q;
  logic [P12_W-1:0] p12_6_q;
  logic [P34_W-1:0] p34_6_q;
  logic [FW-2:0]    f2n, f3n, f4n;

  assign f2n = f2_5_q[FW-2:0];
  assign f3n = f3_5_q[FW-2:0];
  assign f4n = f4_5_q[FW-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok6_q   <= ok5_q;
    p12_6_q <= P12_W'(f1_5_q) * P12_W'(f2n);
    p34_6_q <= P34_W'(f3n) * P34_W'(f4n);
  end

  // Partial products of the full product.
  logic                     v7_q, ok7_q;
  logic [L12_W+L34_W-1:0]   ll7_q;
  logic [L12_W+H34_W-1:0]   lh7_q;
  logic [H12_W+L34_W-1:0]   hl7_q;
  logic [H12_W+H34_W-1:0]   hh7_q;
  logic [L12_W-1:0]         p12_lo;
  logic [H12_W-1:0]         p12_hi;
  logic [L34_W-1:0]         p34_lo;
  logic [H34_W-1:0]         p34_hi;

  assign p12_lo = p12_6_q[L12_W-1:0];
  assign p12_hi = p12_6_q[P12_W-1:L12_W];
  assign p34_lo = p34_6_q[L34_W-1:0];
  assign p34_hi = p34_6_q[P34_W-1:L34_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok7_q <= ok6_q;
    ll7_q <= (L12_W + L34_W)'(p12_lo) * (L12_W + L34_W)'(p34_lo);
    lh7_q <= (L12_W + H34_W)'(p12_lo) * (L12_W + H34_W)'(p34_hi);
    hl7_q <= (H12_W + L34_W)'(p12_hi) * (H12_W + L34_W)'(p34_lo);
    hh7_q <= (H12_W + H34_W)'(p12_hi) * (H12_W + H34_W)'(p34_hi);
  end

  // Summation of the partial products in two steps.
  logic          v8_q, ok8_q;
  logic [PW-1:0] m1_8_q, m2_8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok8_q  <= ok7_q;
    m1_8_q <= PW'(ll7_q) + (PW'(hl7_q) << L12_W);
    m2_8_q <= (PW'(hh7_q) << (L12_W + L34_W)) + (PW'(lh7_q) << L34_W);
  end

  logic          v9_q, ok9_q;
  logic [PW-1:0] prod9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok9_q   <= ok8_q;
    prod9_q <= m1_8_q + m2_8_q;
  end

  // Root of the Heron product.
  logic                 vh_w;
  logic                 okh_w;
  logic [0:0][RT_W-1:0] rooth_w;
  logic [0:0][PW-1:0]   rad_w;

  assign rad_w[0] = prod9_q;

  hta_isqrt #(
    .IN_W  (PW),
    .LANES (1),
    .TAG_W (1)
  ) u_area_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v9_q),
    .radicand_i (rad_w),
    .tag_i      (ok9_q),
    .valid_o    (vh_w),
    .root_o     (rooth_w),
    .tag_o      (okh_w)
  );

  // Output register.
  logic             out_v_q;
  logic             status_q;
  logic [AW-1:0]    area_q;
  logic [RT_W+AW-1:0] root_ext;

  assign root_ext = (RT_W + AW)'(rooth_w[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= vh_w;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= okh_w ? hta_pkg::STATUS_OK : hta_pkg::STATUS_BAD;
    area_q   <= okh_w ? root_ext[AW-1:0] : '0;
  end

  assign valid_o           = out_v_q;
  assign status_o          = status_q;
  assign area_times_four_o = area_q;

endmodule
